// File: rtl/core/ddsw_pkg.sv
// Shared types and constants for the differential drive slew watchdog.
// Holds the payload structs, command and register codes, and reset values.
// No dependencies.
package ddsw_pkg;

  localparam int unsigned LevelBitsDef = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  typedef enum logic [1:0] {
    CMD_DRIVE = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DUTY_FLOOR   = 3'd0,
    CFG_LEFT_INVERT  = 3'd1,
    CFG_RIGHT_INVERT = 3'd2,
    CFG_SLEW_STEP    = 3'd3,
    CFG_SLEW_PERIOD  = 3'd4,
    CFG_IDLE_LIMIT   = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]  DutyFloorRst  = 8'd0;
  localparam logic [14:0] SlewStepRst   = 15'd1638;
  localparam logic [7:0]  SlewPeriodRst = 8'd20;
  localparam logic [15:0] IdleLimitRst  = 16'd500;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
  } in_t;

  typedef struct packed {
    logic               left_fwd;
    logic               left_rev;
    logic [7:0]         left_duty;
    logic               right_fwd;
    logic               right_rev;
    logic [7:0]         right_duty;
    logic               is_driving;
    logic signed [15:0] echo_speed;
    logic signed [15:0] echo_turn;
  } out_t;

  typedef struct packed {
    logic [7:0]  duty_floor;
    logic        left_invert;
    logic        right_invert;
    logic [14:0] slew_step;
    logic [7:0]  slew_period;
    logic [15:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [7:0] duty;
  } bridge_t;

endpackage

// File: rtl/core/ddsw_cfg.sv
// Configuration register file for the drive block.
// Depends on ddsw_pkg for the register codes, reset values and cfg_t.
module ddsw_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ddsw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ddsw_pkg::CfgDataW-1:0]     cfg_data_i,
  output ddsw_pkg::cfg_t                    cfg_o
);

  ddsw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ddsw_pkg::CFG_DUTY_FLOOR:   cfg_d.duty_floor   = cfg_data_i[7:0];
        ddsw_pkg::CFG_LEFT_INVERT:  cfg_d.left_invert  = cfg_data_i[0];
        ddsw_pkg::CFG_RIGHT_INVERT: cfg_d.right_invert = cfg_data_i[0];
        ddsw_pkg::CFG_SLEW_STEP:    cfg_d.slew_step    = cfg_data_i[14:0];
        ddsw_pkg::CFG_SLEW_PERIOD:  cfg_d.slew_period  = cfg_data_i[7:0];
        ddsw_pkg::CFG_IDLE_LIMIT:   cfg_d.idle_limit   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_floor   <= ddsw_pkg::DutyFloorRst;
      cfg_q.left_invert  <= 1'b0;
      cfg_q.right_invert <= 1'b0;
      cfg_q.slew_step    <= ddsw_pkg::SlewStepRst;
      cfg_q.slew_period  <= ddsw_pkg::SlewPeriodRst;
      cfg_q.idle_limit   <= ddsw_pkg::IdleLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ddsw_mixer.sv
// Drive command mixer: clamps speed and turn, forms left and right targets.
// Depends on ddsw_pkg only through the caller; pure combinational logic.
module ddsw_mixer #(
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic signed [15:0]           speed_i,
  input  logic signed [15:0]           turn_i,
  input  logic                         left_invert_i,
  input  logic                         right_invert_i,
  output logic signed [LEVEL_BITS-1:0] held_speed_o,
  output logic signed [LEVEL_BITS-1:0] held_turn_o,
  output logic signed [LEVEL_BITS-1:0] target_left_o,
  output logic signed [LEVEL_BITS-1:0] target_right_o
);

  localparam int unsigned CW = ((LEVEL_BITS > 16) ? LEVEL_BITS : 16) + 2;
  localparam logic signed [CW-1:0] FullC = CW'((1 << (LEVEL_BITS - 1)) - 1);

  function automatic logic signed [CW-1:0] clamp_full(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] r;
    if (x > FullC) begin
      r = FullC;
    end else if (x < -FullC) begin
      r = -FullC;
    end else begin
      r = x;
    end
    return r;
  endfunction

  logic signed [CW-1:0] sv, tv, lm, rm;

  assign sv = clamp_full(CW'(speed_i));
  assign tv = clamp_full(CW'(turn_i));
  assign lm = clamp_full(sv - tv);
  assign rm = clamp_full(sv + tv);

  assign held_speed_o   = LEVEL_BITS'(sv);
  assign held_turn_o    = LEVEL_BITS'(tv);
  assign target_left_o  = LEVEL_BITS'(left_invert_i ? -lm : lm);
  assign target_right_o = LEVEL_BITS'(right_invert_i ? -rm : rm);

endmodule

// File: rtl/core/ddsw_slew.sv
// Slew limiter for one side: moves a level toward its target by at most a step.
// Combinational; no package dependency.
module ddsw_slew #(
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic signed [LEVEL_BITS-1:0] level_i,
  input  logic signed [LEVEL_BITS-1:0] target_i,
  input  logic [14:0]                  step_i,
  output logic signed [LEVEL_BITS-1:0] level_o
);

  localparam int unsigned SW = ((LEVEL_BITS > 15) ? LEVEL_BITS : 15) + 2;

  logic signed [SW-1:0] diff, lim, dc;

  assign diff = SW'(target_i) - SW'(level_i);
  assign lim  = SW'({1'b0, step_i});

  always_comb begin
    if (diff > lim) begin
      dc = lim;
    end else if (diff < -lim) begin
      dc = -lim;
    end else begin
      dc = diff;
    end
  end

  assign level_o = LEVEL_BITS'(SW'(level_i) + dc);

endmodule

// File: rtl/core/ddsw_bridge.sv
// H-bridge pin and duty encoder for one side, with deadband and minimum duty.
// Depends on ddsw_pkg for bridge_t.
module ddsw_bridge #(
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic signed [LEVEL_BITS-1:0] level_i,
  input  logic [7:0]                   duty_floor_i,
  output ddsw_pkg::bridge_t            bridge_o
);

  localparam int unsigned MW = LEVEL_BITS - 1;
  localparam int unsigned AW = LEVEL_BITS + 5;
  localparam int unsigned PW = LEVEL_BITS + 7;
  localparam logic [AW-1:0] FullA = AW'((1 << (LEVEL_BITS - 1)) - 1);

  logic signed [LEVEL_BITS-1:0] neg;
  logic [MW-1:0]                mag;
  logic [AW-1:0]                mag20;
  logic                         dead;
  logic [7:0]                   span;
  logic [PW-1:0]                prod;
  logic [8:0]                   sum;

  assign neg   = -level_i;
  assign mag   = MW'(level_i[LEVEL_BITS-1] ? neg : level_i);
  assign mag20 = AW'({mag, 4'b0}) + AW'({mag, 2'b0});
  assign dead  = mag20 < FullA;
  assign span  = 8'hFF - duty_floor_i;
  assign prod  = PW'(mag) * PW'(span);
  assign sum   = {1'b0, duty_floor_i} + {1'b0, prod[PW-1:MW]};

  assign bridge_o.fwd  = !dead && !level_i[LEVEL_BITS-1];
  assign bridge_o.rev  = !dead && level_i[LEVEL_BITS-1];
  assign bridge_o.duty = dead ? 8'd0 : (sum[8] ? 8'hFF : sum[7:0]);

endmodule

// File: rtl/core/differential_drive_slew_watchdog.sv
// Top level of the differential drive mixer with slew limiter and watchdog.
// Depends on ddsw_pkg, ddsw_cfg, ddsw_mixer, ddsw_slew and ddsw_bridge.
//
// Input channel in_valid_i/in_stall_o carries one command per transfer:
// drive (speed, turn), stop, or a one millisecond tick. Every transfer
// yields exactly one result on out_valid_o/out_stall_i with the bridge pins,
// 8-bit duties, driving flag and the held speed and turn after the update.
// The command is captured in an input register; when it fires, the drive state
// is updated and the result register loaded. Throughput is one command per
// cycle unless the receiver stalls; the single state update per cycle sets
// that figure. While the receiver stalls, the result register holds,
// one more command may wait in the input register, and in_stall_o rises
// only when both are full. The configuration port writes one register per
// cycle with cfg_we_i; write it only while no transfer is in flight.
// Reset restores the register defaults, clears levels, targets, watchdog
// count and slew phase, and empties both registers of the pipeline.
module differential_drive_slew_watchdog #(
  parameter int unsigned LEVEL_BITS = ddsw_pkg::LevelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ddsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ddsw_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ddsw_pkg::out_t                out_data_o
);

  localparam logic signed [LEVEL_BITS-1:0] FullL = LEVEL_BITS'((1 << (LEVEL_BITS - 1)) - 1);

  ddsw_pkg::cfg_t cfg;
  ddsw_pkg::in_t  in_q;
  ddsw_pkg::out_t out_q, out_d;
  logic           in_valid_q, out_valid_q;
  logic           advance, fire, load_in;

  logic signed [LEVEL_BITS-1:0] held_speed_q, held_speed_d, held_turn_q, held_turn_d;
  logic signed [LEVEL_BITS-1:0] target_left_q, target_left_d;
  logic signed [LEVEL_BITS-1:0] target_right_q, target_right_d;
  logic signed [LEVEL_BITS-1:0] level_left_q, level_left_d;
  logic signed [LEVEL_BITS-1:0] level_right_q, level_right_d;
  logic                         active_q, active_d;
  logic [15:0]                  idle_q, idle_d;
  logic [7:0]                   phase_q, phase_d;

  logic signed [LEVEL_BITS-1:0] mix_speed, mix_turn, mix_left, mix_right;
  logic signed [LEVEL_BITS-1:0] slew_left, slew_right;
  logic                         step_now;
  ddsw_pkg::bridge_t            br_left, br_right;

  ddsw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= load_in || (in_valid_q && !advance);
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  ddsw_mixer #(.LEVEL_BITS(LEVEL_BITS)) u_mixer (
    .speed_i        (in_q.speed),
    .turn_i         (in_q.turn),
    .left_invert_i  (cfg.left_invert),
    .right_invert_i (cfg.right_invert),
    .held_speed_o   (mix_speed),
    .held_turn_o    (mix_turn),
    .target_left_o  (mix_left),
    .target_right_o (mix_right)
  );

  ddsw_slew #(.LEVEL_BITS(LEVEL_BITS)) u_slew_left (
    .level_i  (level_left_q),
    .target_i (target_left_q),
    .step_i   (cfg.slew_step),
    .level_o  (slew_left)
  );

  ddsw_slew #(.LEVEL_BITS(LEVEL_BITS)) u_slew_right (
    .level_i  (level_right_q),
    .target_i (target_right_q),
    .step_i   (cfg.slew_step),
    .level_o  (slew_right)
  );

  assign step_now = ({1'b0, phase_q} + 9'd1) >= {1'b0, cfg.slew_period};

  always_comb begin
    held_speed_d   = held_speed_q;
    held_turn_d    = held_turn_q;
    target_left_d  = target_left_q;
    target_right_d = target_right_q;
    level_left_d   = level_left_q;
    level_right_d  = level_right_q;
    active_d       = active_q;
    idle_d         = idle_q;
    phase_d        = phase_q;
    case (in_q.cmd)
      ddsw_pkg::CMD_DRIVE: begin
        held_speed_d   = mix_speed;
        held_turn_d    = mix_turn;
        target_left_d  = mix_left;
        target_right_d = mix_right;
        active_d       = 1'b1;
        idle_d         = '0;
      end
      ddsw_pkg::CMD_STOP: begin
        held_speed_d   = '0;
        held_turn_d    = '0;
        target_left_d  = '0;
        target_right_d = '0;
        level_left_d   = '0;
        level_right_d  = '0;
        active_d       = 1'b0;
      end
      ddsw_pkg::CMD_TICK: begin
        if (step_now) begin
          phase_d       = '0;
          level_left_d  = slew_left;
          level_right_d = slew_right;
        end else begin
          phase_d = phase_q + 8'd1;
        end
        if (idle_q != 16'hFFFF) begin
          idle_d = idle_q + 16'd1;
        end
        if (active_q && (idle_d > cfg.idle_limit)) begin
          held_speed_d   = '0;
          held_turn_d    = '0;
          target_left_d  = '0;
          target_right_d = '0;
          level_left_d   = '0;
          level_right_d  = '0;
          active_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_speed_q   <= '0;
      held_turn_q    <= '0;
      target_left_q  <= '0;
      target_right_q <= '0;
      level_left_q   <= '0;
      level_right_q  <= '0;
      active_q       <= 1'b0;
      idle_q         <= '0;
      phase_q        <= '0;
    end else if (fire) begin
      held_speed_q   <= held_speed_d;
      held_turn_q    <= held_turn_d;
      target_left_q  <= target_left_d;
      target_right_q <= target_right_d;
      level_left_q   <= level_left_d;
      level_right_q  <= level_right_d;
      active_q       <= active_d;
      idle_q         <= idle_d;
      phase_q        <= phase_d;
    end
  end

  ddsw_bridge #(.LEVEL_BITS(LEVEL_BITS)) u_bridge_left (
    .level_i      (level_left_d),
    .duty_floor_i (cfg.duty_floor),
    .bridge_o     (br_left)
  );

  ddsw_bridge #(.LEVEL_BITS(LEVEL_BITS)) u_bridge_right (
    .level_i      (level_right_d),
    .duty_floor_i (cfg.duty_floor),
    .bridge_o     (br_right)
  );

  always_comb begin
    out_d.left_fwd   = br_left.fwd;
    out_d.left_rev   = br_left.rev;
    out_d.left_duty  = br_left.duty;
    out_d.right_fwd  = br_right.fwd;
    out_d.right_rev  = br_right.rev;
    out_d.right_duty = br_right.duty;
    out_d.is_driving = active_d;
    out_d.echo_speed = 16'(held_speed_d);
    out_d.echo_turn  = 16'(held_turn_d);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_held_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (held_speed_q == '0) && (held_turn_q == '0))
    else $error("held command nonzero while not driving");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_left_q <= FullL) && (level_left_q >= -FullL) &&
    (level_right_q <= FullL) && (level_right_q >= -FullL))
    else $error("level outside full scale");

  a_stop_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_q.cmd == ddsw_pkg::CMD_STOP) |=>
      (level_left_q == '0) && (level_right_q == '0) && !active_q)
    else $error("stop did not clear the drive");

  a_pins_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.left_fwd && out_q.left_rev) &&
      !(out_q.right_fwd && out_q.right_rev))
    else $error("bridge pins both high");

endmodule
